// ===== src/spqdk_pkg.sv =====
// Shared types and codes for the stable priority queue with decrease-key.
`timescale 1ns / 1ps
`default_nettype none

package spqdk_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_LOWER  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_NOT_LESS  = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_SIFT_PUT,
        S_POP_RD0,
        S_POP_KEY,
        S_POP_RD,
        S_POP_WR,
        S_FIND_RD,
        S_FIND_CMP,
        S_HEAD,
        S_DONE
    } t_state;

    // Result of the shared compare unit against the working key and priority.
    typedef struct packed {
        logic prio_gt;
        logic key_eq;
    } t_cmp_res;

endpackage

`default_nettype wire

// ===== src/spqdk_ifs.sv =====
// Request and response channel interfaces of the priority queue.
`timescale 1ns / 1ps
`default_nettype none

interface spqdk_req_if #(
    parameter int KEY_BITS  = 16,
    parameter int PRIO_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic [1:0]                  cmd;
    logic [KEY_BITS-1:0]         item_key;
    logic signed [PRIO_BITS-1:0] item_priority;

    modport source (output valid, cmd, item_key, item_priority, input ready);
    modport sink   (input valid, cmd, item_key, item_priority, output ready);
endinterface

interface spqdk_rsp_if #(
    parameter int KEY_BITS  = 16,
    parameter int PRIO_BITS = 16,
    parameter int CNT_W     = 7
);
    logic                        valid;
    logic                        ready;
    logic [2:0]                  status;
    logic [KEY_BITS-1:0]         popped_key;
    logic signed [PRIO_BITS-1:0] old_priority;
    logic                        head_valid;
    logic [KEY_BITS-1:0]         head_key;
    logic signed [PRIO_BITS-1:0] head_priority;
    logic [CNT_W-1:0]            entry_count;

    modport source (output valid, status, popped_key, old_priority, head_valid,
                    head_key, head_priority, entry_count, input ready);
    modport sink   (input valid, status, popped_key, old_priority, head_valid,
                    head_key, head_priority, entry_count, output ready);
endinterface

`default_nettype wire

// ===== src/spqdk_ram.sv =====
// Simple dual-port slot memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module spqdk_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/spqdk_cmp.sv =====
// Shared compare unit: slot priority versus working priority, slot key versus working key.
`timescale 1ns / 1ps
`default_nettype none

module spqdk_cmp #(
    parameter int KEY_BITS  = 16,
    parameter int PRIO_BITS = 16
) (
    input  wire logic [KEY_BITS-1:0]         i_slot_key,
    input  wire logic signed [PRIO_BITS-1:0] i_slot_prio,
    input  wire logic [KEY_BITS-1:0]         i_ref_key,
    input  wire logic signed [PRIO_BITS-1:0] i_ref_prio,
    output spqdk_pkg::t_cmp_res              o_res
);

    always_comb begin
        o_res.prio_gt = (i_slot_prio > i_ref_prio);
        o_res.key_eq  = (i_slot_key == i_ref_key);
    end

endmodule

`default_nettype wire

// ===== src/stable_priority_queue_decrease_key_unit.sv =====
// Commands are served one at a time, visiting slots in turn through the RAM read port and
// the shared comparator: insert walks from the tail, pop shifts every remaining entry,
// lower priority scans for the key and then moves it forward. A new command is taken
// while the last result still waits in the response register.
// Reset (synchronous, active low) empties the queue; slot memory is not initialized.
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue_decrease_key_unit #(
    parameter int CAPACITY  = 64,
    parameter int KEY_BITS  = 16,
    parameter int PRIO_BITS = 16,
    localparam int AW       = $clog2(CAPACITY),
    localparam int CNT_W    = $clog2(CAPACITY + 1),
    localparam int EW       = KEY_BITS + PRIO_BITS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    spqdk_req_if.sink   i_req,
    spqdk_rsp_if.source o_rsp
);

    spqdk_pkg::t_state  r_state, n_state;

    logic [KEY_BITS-1:0]         r_key;
    logic signed [PRIO_BITS-1:0] r_prio;
    logic [AW-1:0]               r_k;
    logic [CNT_W-1:0]            r_count;
    spqdk_pkg::t_status          r_status;
    logic [KEY_BITS-1:0]         r_popped;
    logic signed [PRIO_BITS-1:0] r_oldp;

    logic                        r_rsp_valid;
    spqdk_pkg::t_status          r_o_status;
    logic [KEY_BITS-1:0]         r_o_popped;
    logic signed [PRIO_BITS-1:0] r_o_oldp;
    logic                        r_o_head_valid;
    logic [KEY_BITS-1:0]         r_o_head_key;
    logic signed [PRIO_BITS-1:0] r_o_head_prio;
    logic [CNT_W-1:0]            r_o_count;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [EW-1:0]               ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [EW-1:0]               ram_rdata;
    logic [KEY_BITS-1:0]         rd_key;
    logic signed [PRIO_BITS-1:0] rd_prio;
    spqdk_pkg::t_cmp_res         cmp;

    logic             req_fire;
    logic             rsp_load;
    logic [CNT_W-1:0] k_ext;
    logic             k_next_is_count;
    logic             k_is_count;
    logic             queue_full;
    logic             queue_empty;

    assign rd_key          = ram_rdata[EW-1:PRIO_BITS];
    assign rd_prio         = ram_rdata[PRIO_BITS-1:0];
    assign req_fire        = i_req.valid && i_req.ready;
    assign rsp_load        = (r_state == spqdk_pkg::S_DONE) && (!r_rsp_valid || o_rsp.ready);
    assign k_ext           = CNT_W'(r_k);
    assign k_next_is_count = ((k_ext + CNT_W'(1)) == r_count);
    assign k_is_count      = (k_ext == r_count);
    assign queue_full      = (r_count == CNT_W'(CAPACITY));
    assign queue_empty     = (r_count == '0);

    spqdk_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    spqdk_cmp #(
        .KEY_BITS  (KEY_BITS),
        .PRIO_BITS (PRIO_BITS)
    ) u_cmp (
        .i_slot_key  (rd_key),
        .i_slot_prio (rd_prio),
        .i_ref_key   (r_key),
        .i_ref_prio  (r_prio),
        .o_res       (cmp)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spqdk_pkg::S_IDLE: begin
                if (req_fire) begin
                    unique case (spqdk_pkg::t_cmd'(i_req.cmd))
                        spqdk_pkg::CMD_INSERT: begin
                            if (queue_full) n_state = spqdk_pkg::S_HEAD;
                            else if (queue_empty) n_state = spqdk_pkg::S_SIFT_PUT;
                            else n_state = spqdk_pkg::S_SIFT_RD;
                        end
                        spqdk_pkg::CMD_POP: begin
                            n_state = queue_empty ? spqdk_pkg::S_HEAD : spqdk_pkg::S_POP_RD0;
                        end
                        spqdk_pkg::CMD_LOWER: begin
                            n_state = queue_empty ? spqdk_pkg::S_HEAD : spqdk_pkg::S_FIND_RD;
                        end
                        spqdk_pkg::CMD_CLEAR: n_state = spqdk_pkg::S_HEAD;
                    endcase
                end
            end
            spqdk_pkg::S_SIFT_RD: n_state = spqdk_pkg::S_SIFT_CMP;
            spqdk_pkg::S_SIFT_CMP: begin
                if (cmp.prio_gt && (r_k != AW'(1))) n_state = spqdk_pkg::S_SIFT_RD;
                else n_state = spqdk_pkg::S_SIFT_PUT;
            end
            spqdk_pkg::S_SIFT_PUT: n_state = spqdk_pkg::S_HEAD;
            spqdk_pkg::S_POP_RD0:  n_state = spqdk_pkg::S_POP_KEY;
            spqdk_pkg::S_POP_KEY: begin
                n_state = (r_count == CNT_W'(1)) ? spqdk_pkg::S_HEAD : spqdk_pkg::S_POP_RD;
            end
            spqdk_pkg::S_POP_RD: n_state = spqdk_pkg::S_POP_WR;
            spqdk_pkg::S_POP_WR: begin
                n_state = k_is_count ? spqdk_pkg::S_HEAD : spqdk_pkg::S_POP_RD;
            end
            spqdk_pkg::S_FIND_RD: n_state = spqdk_pkg::S_FIND_CMP;
            spqdk_pkg::S_FIND_CMP: begin
                priority if (cmp.key_eq && !cmp.prio_gt) n_state = spqdk_pkg::S_HEAD;
                else if (cmp.key_eq && (r_k == '0)) n_state = spqdk_pkg::S_SIFT_PUT;
                else if (cmp.key_eq) n_state = spqdk_pkg::S_SIFT_RD;
                else if (k_next_is_count) n_state = spqdk_pkg::S_HEAD;
                else n_state = spqdk_pkg::S_FIND_RD;
            end
            spqdk_pkg::S_HEAD: n_state = spqdk_pkg::S_DONE;
            spqdk_pkg::S_DONE: begin
                if (rsp_load) n_state = spqdk_pkg::S_IDLE;
            end
            default: n_state = spqdk_pkg::S_IDLE;
        endcase
    end

    // Memory port and handshake controls decoded from the state.
    always_comb begin
        i_req.ready = (r_state == spqdk_pkg::S_IDLE);
        ram_we      = 1'b0;
        ram_waddr   = r_k;
        ram_wdata   = ram_rdata;
        ram_raddr   = '0;
        unique case (r_state)
            spqdk_pkg::S_SIFT_RD:  ram_raddr = r_k - AW'(1);
            spqdk_pkg::S_SIFT_CMP: ram_we = cmp.prio_gt;
            spqdk_pkg::S_SIFT_PUT: begin
                ram_we    = 1'b1;
                ram_wdata = {r_key, r_prio};
            end
            spqdk_pkg::S_POP_RD: ram_raddr = r_k;
            spqdk_pkg::S_POP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_k - AW'(1);
            end
            spqdk_pkg::S_FIND_RD: ram_raddr = r_k;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spqdk_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers of the command in progress.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            unique case (r_state)
                spqdk_pkg::S_IDLE: begin
                    if (req_fire) begin
                        r_key    <= i_req.item_key;
                        r_prio   <= i_req.item_priority;
                        r_popped <= '0;
                        r_oldp   <= '0;
                        unique case (spqdk_pkg::t_cmd'(i_req.cmd))
                            spqdk_pkg::CMD_INSERT: begin
                                // Insertion starts at the free slot behind the tail.
                                r_k <= r_count[AW-1:0];
                                if (queue_full) begin
                                    r_status <= spqdk_pkg::ST_FULL;
                                end else begin
                                    r_status <= spqdk_pkg::ST_OK;
                                    r_count  <= r_count + CNT_W'(1);
                                end
                            end
                            spqdk_pkg::CMD_POP: begin
                                r_k      <= '0;
                                r_status <= queue_empty ? spqdk_pkg::ST_EMPTY
                                                        : spqdk_pkg::ST_OK;
                            end
                            spqdk_pkg::CMD_LOWER: begin
                                r_k      <= '0;
                                r_status <= queue_empty ? spqdk_pkg::ST_NOT_FOUND
                                                        : spqdk_pkg::ST_OK;
                            end
                            spqdk_pkg::CMD_CLEAR: begin
                                r_k      <= '0;
                                r_status <= spqdk_pkg::ST_OK;
                                r_count  <= '0;
                            end
                        endcase
                    end
                end
                spqdk_pkg::S_SIFT_CMP: begin
                    if (cmp.prio_gt) r_k <= r_k - AW'(1);
                end
                spqdk_pkg::S_POP_KEY: begin
                    r_popped <= rd_key;
                    r_count  <= r_count - CNT_W'(1);
                    r_k      <= AW'(1);
                end
                spqdk_pkg::S_POP_WR: r_k <= r_k + AW'(1);
                spqdk_pkg::S_FIND_CMP: begin
                    if (cmp.key_eq && !cmp.prio_gt) begin
                        r_status <= spqdk_pkg::ST_NOT_LESS;
                        r_oldp   <= rd_prio;
                    end else if (!cmp.key_eq) begin
                        if (k_next_is_count) r_status <= spqdk_pkg::ST_NOT_FOUND;
                        else r_k <= r_k + AW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Response register; the head slot was read in the cycle before the load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (rsp_load) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_load) begin
            r_o_status     <= r_status;
            r_o_popped     <= r_popped;
            r_o_oldp       <= r_oldp;
            r_o_head_valid <= !queue_empty;
            r_o_head_key   <= queue_empty ? '0 : rd_key;
            r_o_head_prio  <= queue_empty ? '0 : rd_prio;
            r_o_count      <= r_count;
        end
    end

    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.popped_key    = r_o_popped;
    assign o_rsp.old_priority  = r_o_oldp;
    assign o_rsp.head_valid    = r_o_head_valid;
    assign o_rsp.head_key      = r_o_head_key;
    assign o_rsp.head_priority = r_o_head_prio;
    assign o_rsp.entry_count   = r_o_count;

endmodule

`default_nettype wire

// ===== src/spqdk_chk.sv =====
// Port-level checker for the priority queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module spqdk_chk #(
    parameter int CAPACITY  = 64,
    parameter int KEY_BITS  = 16,
    parameter int PRIO_BITS = 16,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_rsp_valid,
    input wire logic                 i_rsp_ready,
    input wire logic [2:0]           i_status,
    input wire logic [KEY_BITS-1:0]  i_popped_key,
    input wire logic                 i_head_valid,
    input wire logic [KEY_BITS-1:0]  i_head_key,
    input wire logic [PRIO_BITS-1:0] i_head_priority,
    input wire logic [CNT_W-1:0]     i_entry_count
);

    // A stalled response stays valid and keeps its status, popped key, entry count and head key.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status)
            && $stable(i_popped_key) && $stable(i_entry_count) && $stable(i_head_key))
        else $error("response changed while stalled");

    // The head fields agree with the entry count, and an empty queue reports zeros.
    a_head_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_head_valid == (i_entry_count != '0))
            && (i_head_valid || (i_head_key == '0 && i_head_priority == '0)))
        else $error("head fields disagree with entry count");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == spqdk_pkg::ST_FULL)
            |-> (i_entry_count == CNT_W'(CAPACITY)))
        else $error("full status with room left");

    // A pop that fails leaves an empty queue and removes nothing.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == spqdk_pkg::ST_EMPTY)
            |-> (i_entry_count == '0) && (i_popped_key == '0))
        else $error("empty status on a non-empty queue");

endmodule

bind stable_priority_queue_decrease_key_unit spqdk_chk #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .PRIO_BITS (PRIO_BITS)
) u_spqdk_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_status        (o_rsp.status),
    .i_popped_key    (o_rsp.popped_key),
    .i_head_valid    (o_rsp.head_valid),
    .i_head_key      (o_rsp.head_key),
    .i_head_priority (o_rsp.head_priority),
    .i_entry_count   (o_rsp.entry_count)
);

`default_nettype wire

// ===== tb/sv/stable_priority_queue_decrease_key_unit_test.sv =====
// Self-checking testbench for the stable priority queue with decrease-key.
`timescale 1ns / 1ps

module stable_priority_queue_decrease_key_unit_test;

    localparam int CAPACITY    = 64;
    localparam int KEY_BITS    = 16;
    localparam int PRIO_BITS   = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 300;
    localparam int MIXED_ITEMS = 48;

    typedef struct packed {
        spqdk_pkg::t_status          status;
        logic [KEY_BITS-1:0]         popped_key;
        logic signed [PRIO_BITS-1:0] old_priority;
        logic                        head_valid;
        logic [KEY_BITS-1:0]         head_key;
        logic signed [PRIO_BITS-1:0] head_priority;
        logic [6:0]                  entry_count;
    } t_result;

    typedef struct {
        spqdk_pkg::t_cmd             cmd;
        logic [KEY_BITS-1:0]         key;
        logic signed [PRIO_BITS-1:0] prio;
        bit                          typed;
        t_result                     want;
    } t_step;

    logic i_clk;
    logic i_rst_n;

    spqdk_req_if #(.KEY_BITS(KEY_BITS), .PRIO_BITS(PRIO_BITS)) req_ch ();
    spqdk_rsp_if #(.KEY_BITS(KEY_BITS), .PRIO_BITS(PRIO_BITS), .CNT_W(7)) rsp_ch ();

    stable_priority_queue_decrease_key_unit #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS),
        .PRIO_BITS(PRIO_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // Sorted contents as the queue should hold them; slot 0 is the head.
    logic [KEY_BITS-1:0]         queue_keys  [CAPACITY];
    logic signed [PRIO_BITS-1:0] queue_prios [CAPACITY];
    int                          queue_count;

    t_result pending_results[$];
    int      mismatch_count;
    int      cycle_count;
    int      send_idle_pct;
    int      recv_stall_pct;

    // Directed sequence. Only rows whose result is plain are typed in.
    t_step plan [0:22] = '{
        '{spqdk_pkg::CMD_POP,    16'h0000, 16'sh0000, 1'b1,
          '{spqdk_pkg::ST_EMPTY, 16'h0, 16'sh0, 1'b0, 16'h0, 16'sh0, 7'd0}},
        '{spqdk_pkg::CMD_LOWER,  16'h1234, 16'sh0000, 1'b1,
          '{spqdk_pkg::ST_NOT_FOUND, 16'h0, 16'sh0, 1'b0, 16'h0, 16'sh0, 7'd0}},
        '{spqdk_pkg::CMD_CLEAR,  16'h0000, 16'sh0000, 1'b1,
          '{spqdk_pkg::ST_OK, 16'h0, 16'sh0, 1'b0, 16'h0, 16'sh0, 7'd0}},
        '{spqdk_pkg::CMD_INSERT, 16'hffff, 16'sh7fff, 1'b1,
          '{spqdk_pkg::ST_OK, 16'h0, 16'sh0, 1'b1, 16'hffff, 16'sh7fff, 7'd1}},
        '{spqdk_pkg::CMD_INSERT, 16'h0000, 16'sh8000, 1'b1,
          '{spqdk_pkg::ST_OK, 16'h0, 16'sh0, 1'b1, 16'h0000, 16'sh8000, 7'd2}},
        '{spqdk_pkg::CMD_INSERT, 16'h0055, 16'sd100, 1'b0, '0},
        '{spqdk_pkg::CMD_INSERT, 16'h0066, 16'sd100, 1'b0, '0},
        '{spqdk_pkg::CMD_INSERT, 16'h0055, 16'sd50,  1'b0, '0},
        '{spqdk_pkg::CMD_LOWER,  16'h0055, 16'sd50,  1'b0, '0},
        '{spqdk_pkg::CMD_LOWER,  16'h0066, 16'sd200, 1'b0, '0},
        '{spqdk_pkg::CMD_LOWER,  16'h0077, 16'sd0,   1'b0, '0},
        '{spqdk_pkg::CMD_LOWER,  16'hffff, 16'sd100, 1'b0, '0},
        '{spqdk_pkg::CMD_LOWER,  16'h0066, 16'sh8000, 1'b0, '0},
        '{spqdk_pkg::CMD_LOWER,  16'h0000, 16'sh8000, 1'b0, '0},
        '{spqdk_pkg::CMD_POP,    16'h0000, 16'sh0000, 1'b0, '0},
        '{spqdk_pkg::CMD_POP,    16'h0000, 16'sh0000, 1'b0, '0},
        '{spqdk_pkg::CMD_INSERT, 16'haaaa, 16'shffff, 1'b0, '0},
        '{spqdk_pkg::CMD_INSERT, 16'h5555, 16'sh0000, 1'b0, '0},
        '{spqdk_pkg::CMD_CLEAR,  16'h0000, 16'sh0000, 1'b1,
          '{spqdk_pkg::ST_OK, 16'h0, 16'sh0, 1'b0, 16'h0, 16'sh0, 7'd0}},
        '{spqdk_pkg::CMD_POP,    16'h0000, 16'sh0000, 1'b1,
          '{spqdk_pkg::ST_EMPTY, 16'h0, 16'sh0, 1'b0, 16'h0, 16'sh0, 7'd0}},
        '{spqdk_pkg::CMD_INSERT, 16'h1234, 16'sh7fff, 1'b0, '0},
        '{spqdk_pkg::CMD_LOWER,  16'h1234, 16'sh7ffe, 1'b0, '0},
        '{spqdk_pkg::CMD_POP,    16'h0000, 16'sh0000, 1'b0, '0}
    };

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Applies one command to the local copy of the queue and returns its result.
    function automatic t_result apply_command(spqdk_pkg::t_cmd c, logic [KEY_BITS-1:0] k,
                                              logic signed [PRIO_BITS-1:0] p);
        t_result r;
        int      idx;
        int      pos;
        r = '0;
        r.status = spqdk_pkg::ST_OK;
        case (c)
            spqdk_pkg::CMD_INSERT: begin
                if (queue_count >= CAPACITY) begin
                    r.status = spqdk_pkg::ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < queue_count && queue_prios[pos] <= p) pos++;
                    for (int j = queue_count; j > pos; j--) begin
                        queue_keys[j]  = queue_keys[j-1];
                        queue_prios[j] = queue_prios[j-1];
                    end
                    queue_keys[pos]  = k;
                    queue_prios[pos] = p;
                    queue_count++;
                end
            end
            spqdk_pkg::CMD_POP: begin
                if (queue_count == 0) begin
                    r.status = spqdk_pkg::ST_EMPTY;
                end else begin
                    r.popped_key = queue_keys[0];
                    for (int j = 0; j < queue_count - 1; j++) begin
                        queue_keys[j]  = queue_keys[j+1];
                        queue_prios[j] = queue_prios[j+1];
                    end
                    queue_count--;
                end
            end
            spqdk_pkg::CMD_LOWER: begin
                idx = 0;
                while (idx < queue_count && queue_keys[idx] != k) idx++;
                if (idx >= queue_count) begin
                    r.status = spqdk_pkg::ST_NOT_FOUND;
                end else if (queue_prios[idx] <= p) begin
                    r.status       = spqdk_pkg::ST_NOT_LESS;
                    r.old_priority = queue_prios[idx];
                end else begin
                    // The entry moves forward, behind everything equal or more urgent.
                    pos = 0;
                    while (pos < idx && queue_prios[pos] <= p) pos++;
                    for (int j = idx; j > pos; j--) begin
                        queue_keys[j]  = queue_keys[j-1];
                        queue_prios[j] = queue_prios[j-1];
                    end
                    queue_keys[pos]  = k;
                    queue_prios[pos] = p;
                end
            end
            default: queue_count = 0;
        endcase
        if (queue_count > 0) begin
            r.head_valid    = 1'b1;
            r.head_key      = queue_keys[0];
            r.head_priority = queue_prios[0];
        end
        r.entry_count = queue_count[6:0];
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic issue_command(spqdk_pkg::t_cmd c, logic [KEY_BITS-1:0] k,
                                 logic signed [PRIO_BITS-1:0] p,
                                 bit typed, t_result want);
        t_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.cmd           <= c;
        req_ch.item_key      <= k;
        req_ch.item_priority <= p;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = apply_command(c, k, p);
        pending_results.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key();
        return ($urandom_range(1)) ? KEY_BITS'($urandom_range(31)) : KEY_BITS'($urandom);
    endfunction

    function automatic logic signed [PRIO_BITS-1:0] pick_priority();
        int v;
        if ($urandom_range(1))
            v = int'($urandom_range(40)) - 20;
        else
            v = int'($urandom_range(65535)) - 32768;
        return PRIO_BITS'(v);
    endfunction

    task automatic mixed_command();
        int                          roll;
        int                          idx;
        int                          target;
        logic [KEY_BITS-1:0]         k;
        logic signed [PRIO_BITS-1:0] p;
        roll = $urandom_range(99);
        k    = pick_key();
        p    = pick_priority();
        if (roll < 35) begin
            issue_command(spqdk_pkg::CMD_INSERT, k, p, 1'b0, '0);
        end else if (roll < 60) begin
            issue_command(spqdk_pkg::CMD_POP, k, p, 1'b0, '0);
        end else if (roll < 96) begin
            // Mostly aim at a held key so that real moves happen.
            if (queue_count > 0 && $urandom_range(99) < 80) begin
                idx    = $urandom_range(queue_count - 1);
                k      = queue_keys[idx];
                target = int'(queue_prios[idx]);
                roll   = $urandom_range(99);
                if (roll < 15)
                    target = target;
                else if (roll < 25)
                    target = target + int'($urandom_range(50));
                else
                    target = target - int'($urandom_range(100, 1));
                if (target > 32767) target = 32767;
                if (target < -32768) target = -32768;
                p = PRIO_BITS'(target);
            end
            issue_command(spqdk_pkg::CMD_LOWER, k, p, 1'b0, '0);
        end else begin
            issue_command(spqdk_pkg::CMD_CLEAR, k, p, 1'b0, '0);
        end
    endtask

    initial begin
        int full_hits;
        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.cmd           = spqdk_pkg::CMD_INSERT;
        req_ch.item_key      = '0;
        req_ch.item_priority = '0;
        rsp_ch.ready         = 1'b0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        queue_count          = 0;
        mismatch_count       = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[n])
            issue_command(plan[n].cmd, plan[n].key, plan[n].prio, plan[n].typed, plan[n].want);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            // Fill the queue and push three inserts against the full state.
            full_hits = 0;
            while (full_hits < 3) begin
                if (queue_count == CAPACITY) full_hits++;
                issue_command(spqdk_pkg::CMD_INSERT, pick_key(), pick_priority(), 1'b0, '0);
            end
            for (int n = 0; n < MIXED_ITEMS; n++) mixed_command();
        end
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("** stable_priority_queue_decrease_key_unit: PASSED **");
        else
            $display("** stable_priority_queue_decrease_key_unit: FAILED **");
        $finish;
    end

    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result exp_res;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.status        = spqdk_pkg::t_status'(rsp_ch.status);
            got.popped_key    = rsp_ch.popped_key;
            got.old_priority  = rsp_ch.old_priority;
            got.head_valid    = rsp_ch.head_valid;
            got.head_key      = rsp_ch.head_key;
            got.head_priority = rsp_ch.head_priority;
            got.entry_count   = rsp_ch.entry_count;
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("%0t: result with no command waiting: status %0d count %0d",
                             $realtime, got.status, got.entry_count);
                mismatch_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (got.status !== exp_res.status
                        || got.popped_key !== exp_res.popped_key
                        || got.old_priority !== exp_res.old_priority
                        || got.head_valid !== exp_res.head_valid
                        || got.head_key !== exp_res.head_key
                        || got.head_priority !== exp_res.head_priority
                        || got.entry_count !== exp_res.entry_count) begin
                    if (mismatch_count < 10) begin
                        $display({"%0t: mismatch, expected st %0d pop %h old %0d",
                                  " hv %b hk %h hp %0d n %0d"},
                                 $realtime, exp_res.status, exp_res.popped_key,
                                 exp_res.old_priority, exp_res.head_valid, exp_res.head_key,
                                 exp_res.head_priority, exp_res.entry_count);
                        $display({"%0t:           got      st %0d pop %h old %0d",
                                  " hv %b hk %h hp %0d n %0d"},
                                 $realtime, got.status, got.popped_key, got.old_priority,
                                 got.head_valid, got.head_key, got.head_priority,
                                 got.entry_count);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** stable_priority_queue_decrease_key_unit: FAILED **");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
src/spqdk_pkg.sv
src/spqdk_ifs.sv
src/spqdk_ram.sv
src/spqdk_cmp.sv
src/stable_priority_queue_decrease_key_unit.sv
src/spqdk_chk.sv
tb/sv/stable_priority_queue_decrease_key_unit_test.sv
